// File: rtl/polygon_bounds_and_area_assert.svh
// assertion macros for the polygon bounds and area block
`ifndef POLYGON_BOUNDS_AND_AREA_ASSERT_SVH
`define POLYGON_BOUNDS_AND_AREA_ASSERT_SVH

`ifndef SYNTHESIS

// implication checked at every clock edge outside reset
`define PBA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// plain condition checked at every clock edge outside reset
`define PBA_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`else

`define PBA_ASSERT_IMPL(name, ante, cons, msg)

`define PBA_ASSERT_ALWAYS(name, cond, msg)

`endif

`endif

// File: rtl/pba_pkg.sv
// shared types and constants of the polygon bounds and area block
package pba_pkg;

    localparam int FIELD_W     = 24;
    localparam int COUNT_OUT_W = 13;
    localparam int AREA_W      = 64;

    localparam int MIN_POLY_VERTICES = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
    localparam logic signed [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic                      last;
    } in_item_t;

    typedef struct packed {
        logic signed [AREA_W-1:0]  twice_area;
        logic signed [FIELD_W-1:0] min_x;
        logic signed [FIELD_W-1:0] min_y;
        logic signed [FIELD_W-1:0] max_x;
        logic signed [FIELD_W-1:0] max_y;
        logic [COUNT_OUT_W-1:0]    vertex_count;
        logic                      area_overflow;
    } out_item_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

// File: rtl/pba_queue.sv
// short queue of classified vertices between front and back
module pba_queue
    import pba_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output q_status_t        status
);

    logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

// File: rtl/pba_front.sv
// front end: takes vertices, tracks first and previous vertex, forms operands
module pba_front
    import pba_pkg::*;
#(
    parameter int COORD_BITS   = 24,
    parameter int MAX_VERTICES = 4096,
    parameter int CNT_W        = 13,
    localparam int ENTRY_W     = 6 * COORD_BITS + CNT_W + 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  in_item_t           in_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  q_status_t          q_status,
    output logic               push,
    output logic [ENTRY_W-1:0] entry
);

    typedef struct packed {
        logic signed [COORD_BITS:0]   a1;
        logic signed [COORD_BITS:0]   b1;
        logic signed [COORD_BITS:0]   a2;
        logic signed [COORD_BITS:0]   b2;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         is_first;
        logic                         last;
        logic [CNT_W-1:0]             count;
    } entry_t;

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_VERTICES);

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic signed [COORD_BITS-1:0] first_x_reg;
    logic signed [COORD_BITS-1:0] first_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;

    logic [COORD_BITS+FIELD_W-1:0] ext_x;
    logic [COORD_BITS+FIELD_W-1:0] ext_y;
    logic signed [COORD_BITS-1:0]  cx;
    logic signed [COORD_BITS-1:0]  cy;
    logic signed [COORD_BITS-1:0]  fx;
    logic signed [COORD_BITS-1:0]  fy;
    logic [CNT_W-1:0]              count_inc;
    logic                          is_first;
    entry_t                        e;

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        // low COORD_BITS bits of the field, read as two's complement
        ext_x     = {{COORD_BITS{1'b0}}, in_data.x};
        ext_y     = {{COORD_BITS{1'b0}}, in_data.y};
        cx        = signed'(ext_x[COORD_BITS-1:0]);
        cy        = signed'(ext_y[COORD_BITS-1:0]);
        is_first  = (count_reg == '0);
        fx        = is_first ? cx : first_x_reg;
        fy        = is_first ? cy : first_y_reg;
        count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

        e.a1       = is_first ? '0 : {cy[COORD_BITS-1], cy} + {prev_y_reg[COORD_BITS-1], prev_y_reg};
        e.b1       = is_first ? '0 : {cx[COORD_BITS-1], cx} - {prev_x_reg[COORD_BITS-1], prev_x_reg};
        e.a2       = {fy[COORD_BITS-1], fy} + {cy[COORD_BITS-1], cy};
        e.b2       = {fx[COORD_BITS-1], fx} - {cx[COORD_BITS-1], cx};
        e.x        = cx;
        e.y        = cy;
        e.is_first = is_first;
        e.last     = in_data.last;
        e.count    = count_inc;

        // a last vertex closes the polygon, the next item starts a new one
        count_next = count_reg;
        if (push)
        begin
            count_next = in_data.last ? '0 : count_inc;
        end
    end

    assign entry = e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            prev_x_reg <= cx;
            prev_y_reg <= cy;
            if (is_first)
            begin
                first_x_reg <= cx;
                first_y_reg <= cy;
            end
        end
    end

endmodule

// File: rtl/pba_back.sv
// back end: shoelace products, saturating sum, bounding box, result register
module pba_back
    import pba_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int CNT_W      = 13,
    localparam int ENTRY_W   = 6 * COORD_BITS + CNT_W + 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  q_status_t          q_status,
    input  logic [ENTRY_W-1:0] pop_data,
    output logic               pop,
    output out_item_t          out_data,
    output logic               out_valid,
    input  logic               out_ready
);

    typedef struct packed {
        logic signed [COORD_BITS:0]   a1;
        logic signed [COORD_BITS:0]   b1;
        logic signed [COORD_BITS:0]   a2;
        logic signed [COORD_BITS:0]   b2;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         is_first;
        logic                         last;
        logic [CNT_W-1:0]             count;
    } entry_t;

    localparam int PW = 2 * COORD_BITS + 2;
    localparam logic [CNT_W-1:0] COUNT_ENOUGH = CNT_W'(MIN_POLY_VERTICES);

    function automatic logic signed [AREA_W-1:0] widen(input logic signed [PW-1:0] p);
        return {{(AREA_W-PW){p[PW-1]}}, p};
    endfunction

    // returns {overflow, sum}; a sum that has saturated stays frozen
    function automatic logic [AREA_W:0] sat_add(input logic signed [AREA_W-1:0] acc,
                                                 input logic                     ovf,
                                                 input logic signed [AREA_W-1:0] term);
        logic signed [AREA_W-1:0] s;
        logic [AREA_W:0]          r;
        s = acc + term;
        if (ovf)
        begin
            r = {1'b1, acc};
        end
        else if ((acc[AREA_W-1] == term[AREA_W-1]) && (s[AREA_W-1] != acc[AREA_W-1]))
        begin
            r = {1'b1, acc[AREA_W-1] ? AREA_MIN : AREA_MAX};
        end
        else
        begin
            r = {1'b0, s};
        end
        return r;
    endfunction

    function automatic logic signed [FIELD_W-1:0] to_field(input logic signed [COORD_BITS-1:0] v);
        logic [COORD_BITS+FIELD_W-1:0] t;
        t = {{FIELD_W{v[COORD_BITS-1]}}, v};
        return signed'(t[FIELD_W-1:0]);
    endfunction

    entry_t e;
    assign e = pop_data;

    // multiply stage
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic signed [PW-1:0]         m_prod1_reg;
    logic signed [PW-1:0]         m_prod2_reg;
    logic signed [COORD_BITS-1:0] m_x_reg;
    logic signed [COORD_BITS-1:0] m_y_reg;
    logic                         m_first_reg;
    logic                         m_last_reg;
    logic [CNT_W-1:0]             m_count_reg;

    // running polygon state
    logic signed [AREA_W-1:0]     acc_sum_reg;
    logic                         acc_ovf_reg;
    logic signed [COORD_BITS-1:0] box_min_x_reg;
    logic signed [COORD_BITS-1:0] box_min_y_reg;
    logic signed [COORD_BITS-1:0] box_max_x_reg;
    logic signed [COORD_BITS-1:0] box_max_y_reg;

    // closing stage, holds a finished polygon before the closing term
    logic                         f_valid_reg;
    logic                         f_valid_next;
    logic signed [AREA_W-1:0]     f_sum_reg;
    logic                         f_ovf_reg;
    logic signed [PW-1:0]         f_term_reg;
    logic signed [COORD_BITS-1:0] f_min_x_reg;
    logic signed [COORD_BITS-1:0] f_min_y_reg;
    logic signed [COORD_BITS-1:0] f_max_x_reg;
    logic signed [COORD_BITS-1:0] f_max_y_reg;
    logic [CNT_W-1:0]             f_count_reg;

    logic      o_valid_reg;
    logic      o_valid_next;
    out_item_t o_data_reg;
    out_item_t o_data_next;

    logic m_consume;
    logic m_ready;
    logic f_ready;
    logic f_fire;
    logic o_ready;

    logic signed [AREA_W-1:0]     base_sum;
    logic                         base_ovf;
    logic [AREA_W:0]              acc_res;
    logic signed [COORD_BITS-1:0] nmin_x;
    logic signed [COORD_BITS-1:0] nmin_y;
    logic signed [COORD_BITS-1:0] nmax_x;
    logic signed [COORD_BITS-1:0] nmax_y;
    logic [AREA_W:0]              fin_res;
    logic                         enough;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    assign o_ready   = !o_valid_reg || out_ready;
    assign f_fire    = f_valid_reg && o_ready;
    assign f_ready   = !f_valid_reg || o_ready;
    assign m_consume = m_valid_reg && (!m_last_reg || f_ready);
    assign m_ready   = !m_valid_reg || m_consume;
    assign pop       = !q_status.empty && m_ready;

    always_comb
    begin
        base_sum = m_first_reg ? '0 : acc_sum_reg;
        base_ovf = m_first_reg ? 1'b0 : acc_ovf_reg;
        acc_res  = sat_add(base_sum, base_ovf, widen(m_prod1_reg));

        if (m_first_reg)
        begin
            nmin_x = m_x_reg;
            nmax_x = m_x_reg;
            nmin_y = m_y_reg;
            nmax_y = m_y_reg;
        end
        else
        begin
            nmin_x = (m_x_reg < box_min_x_reg) ? m_x_reg : box_min_x_reg;
            nmax_x = (m_x_reg > box_max_x_reg) ? m_x_reg : box_max_x_reg;
            nmin_y = (m_y_reg < box_min_y_reg) ? m_y_reg : box_min_y_reg;
            nmax_y = (m_y_reg > box_max_y_reg) ? m_y_reg : box_max_y_reg;
        end

        fin_res   = sat_add(f_sum_reg, f_ovf_reg, widen(f_term_reg));
        enough    = (f_count_reg >= COUNT_ENOUGH);
        count_ext = {{COUNT_OUT_W{1'b0}}, f_count_reg};

        o_data_next.twice_area    = enough ? signed'(fin_res[AREA_W-1:0]) : '0;
        o_data_next.area_overflow = enough && fin_res[AREA_W];
        o_data_next.min_x         = to_field(f_min_x_reg);
        o_data_next.min_y         = to_field(f_min_y_reg);
        o_data_next.max_x         = to_field(f_max_x_reg);
        o_data_next.max_y         = to_field(f_max_y_reg);
        o_data_next.vertex_count  = count_ext[COUNT_OUT_W-1:0];

        m_valid_next = pop ? 1'b1 : (m_consume ? 1'b0 : m_valid_reg);
        f_valid_next = (m_consume && m_last_reg) ? 1'b1 : (f_fire ? 1'b0 : f_valid_reg);
        o_valid_next = f_fire ? 1'b1 : (out_ready ? 1'b0 : o_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            f_valid_reg <= f_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_prod1_reg <= e.a1 * e.b1;
            m_prod2_reg <= e.a2 * e.b2;
            m_x_reg     <= e.x;
            m_y_reg     <= e.y;
            m_first_reg <= e.is_first;
            m_last_reg  <= e.last;
            m_count_reg <= e.count;
        end
        if (m_consume)
        begin
            acc_sum_reg   <= signed'(acc_res[AREA_W-1:0]);
            acc_ovf_reg   <= acc_res[AREA_W];
            box_min_x_reg <= nmin_x;
            box_min_y_reg <= nmin_y;
            box_max_x_reg <= nmax_x;
            box_max_y_reg <= nmax_y;
            if (m_last_reg)
            begin
                f_sum_reg   <= signed'(acc_res[AREA_W-1:0]);
                f_ovf_reg   <= acc_res[AREA_W];
                f_term_reg  <= m_prod2_reg;
                f_min_x_reg <= nmin_x;
                f_min_y_reg <= nmin_y;
                f_max_x_reg <= nmax_x;
                f_max_y_reg <= nmax_y;
                f_count_reg <= m_count_reg;
            end
        end
        if (f_fire)
        begin
            o_data_reg <= o_data_next;
        end
    end

    assign out_data  = o_data_reg;
    assign out_valid = o_valid_reg;

endmodule

// File: rtl/polygon_bounds_and_area.sv
// top level of the polygon bounds and area block
//
//  channel  direction  payload      handshake
//  -------  ---------  -----------  --------------------
//  in       input      in_item_t    in_valid / in_ready
//  out      output     out_item_t   out_valid / out_ready
//
// one vertex per cycle while the queue has room; the queue takes the item at the accepting edge,
// then the product stage, the accumulate stage and the closing-term add are registered in turn
// before a last vertex raises out_valid.
// reset clears only the handshake and count state, no clearing pass is needed.
// a four-entry queue sits between front and back, so vertices keep coming in
// while a result waits on out_ready, until the queue fills.
module polygon_bounds_and_area
    import pba_pkg::*;
#(
    parameter int MAX_VERTICES = 4096,
    parameter int COORD_BITS   = 24
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  logic      in_valid,
    output logic      in_ready,
    output out_item_t out_data,
    output logic      out_valid,
    input  logic      out_ready
);

`include "polygon_bounds_and_area_assert.svh"

    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int ENTRY_W = 6 * COORD_BITS + CNT_W + 6;

    q_status_t          q_status;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] push_data;
    logic [ENTRY_W-1:0] pop_data;

    pba_front #(
        .COORD_BITS   (COORD_BITS),
        .MAX_VERTICES (MAX_VERTICES),
        .CNT_W        (CNT_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_status (q_status),
        .push     (push),
        .entry    (push_data)
    );

    pba_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    pba_back #(
        .COORD_BITS (COORD_BITS),
        .CNT_W      (CNT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    // a flagged overflow leaves the area pinned at one of the bounds
    `PBA_ASSERT_IMPL(a_ovf_at_bound, out_valid && out_data.area_overflow, out_data.twice_area == AREA_MAX || out_data.twice_area == AREA_MIN, "overflow flagged with area off the bounds")
    // the box never turns inside out when coordinates fit the fields
    `PBA_ASSERT_IMPL(a_box_order, (COORD_BITS <= FIELD_W) && out_valid, (out_data.min_x <= out_data.max_x) && (out_data.min_y <= out_data.max_y), "bounding box min above max")
    // queue fill moves by at most one entry a cycle and never passes depth
    `PBA_ASSERT_ALWAYS(a_queue_fill, (q_status.count <= QCNT_W'(QUEUE_DEPTH)) && (q_status.count == $past(q_status.count) || q_status.count == $past(q_status.count) + 1'b1 || q_status.count == $past(q_status.count) - 1'b1), "queue fill jumped")

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the polygon bounds and area block
module tb;
    import pba_pkg::*;

    localparam int MAX_VERTICES    = 4096;
    localparam int RANDOM_VERTICES = 1180;
    localparam int DRAIN_CYCLES    = 20;

    localparam logic signed [FIELD_W-1:0] COORD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam logic signed [FIELD_W-1:0] COORD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};

    // coordinate styles for random polygons
    typedef enum int {STYLE_FULL, STYLE_SMALL, STYLE_MIXED} coord_style_t;

    logic      clk;
    logic      rst_n;
    in_item_t  in_data;
    logic      in_valid;
    logic      in_ready;
    out_item_t out_data;
    logic      out_valid;
    logic      out_ready;

    // running polygon state of the predictor
    logic signed [FIELD_W-1:0] first_x, first_y, prev_x, prev_y;
    logic signed [FIELD_W-1:0] box_lo_x, box_lo_y, box_hi_x, box_hi_y;
    longint                    area_acc;
    int                        vertices_seen;
    bit                        area_sat;

    out_item_t pending_shapes[$];
    bit        gaps_on;
    int        errors;
    int        vertices_sent;
    int        shapes_sent;
    int        shapes_checked;
    int        sat_shapes;

    polygon_bounds_and_area dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin : run_limit
        #(40_000_000);
        $display("FAIL polygon_bounds_and_area");
        $finish;
    end

    task automatic clear_shape_state();
        first_x       = '0;
        first_y       = '0;
        prev_x        = '0;
        prev_y        = '0;
        box_lo_x      = '0;
        box_lo_y      = '0;
        box_hi_x      = '0;
        box_hi_y      = '0;
        area_acc      = 0;
        vertices_seen = 0;
        area_sat      = 1'b0;
    endtask

    // saturating add; once saturated the sum stays put until the polygon ends
    task automatic add_area_term(input longint term);
        if (!area_sat)
        begin
            if (term > 0 && area_acc > AREA_MAX - term)
            begin
                area_acc = AREA_MAX;
                area_sat = 1'b1;
            end
            else if (term < 0 && area_acc < AREA_MIN - term)
            begin
                area_acc = AREA_MIN;
                area_sat = 1'b1;
            end
            else
            begin
                area_acc += term;
            end
        end
    endtask

    task automatic track_vertex(input in_item_t v);
        out_item_t shape;
        bit        enough;
        if (vertices_seen == 0)
        begin
            first_x  = v.x;
            first_y  = v.y;
            box_lo_x = v.x;
            box_hi_x = v.x;
            box_lo_y = v.y;
            box_hi_y = v.y;
        end
        else
        begin
            add_area_term((longint'(v.y) + longint'(prev_y)) *
                          (longint'(v.x) - longint'(prev_x)));
            if (v.x < box_lo_x) box_lo_x = v.x;
            if (v.x > box_hi_x) box_hi_x = v.x;
            if (v.y < box_lo_y) box_lo_y = v.y;
            if (v.y > box_hi_y) box_hi_y = v.y;
        end
        if (vertices_seen < MAX_VERTICES)
            vertices_seen++;
        prev_x = v.x;
        prev_y = v.y;
        if (v.last)
        begin
            // closing edge back to the first vertex
            add_area_term((longint'(first_y) + longint'(v.y)) *
                          (longint'(first_x) - longint'(v.x)));
            enough              = vertices_seen >= MIN_POLY_VERTICES;
            shape.twice_area    = enough ? area_acc : '0;
            shape.min_x         = box_lo_x;
            shape.min_y         = box_lo_y;
            shape.max_x         = box_hi_x;
            shape.max_y         = box_hi_y;
            shape.vertex_count  = vertices_seen[COUNT_OUT_W-1:0];
            shape.area_overflow = enough && area_sat;
            if (shape.area_overflow)
                sat_shapes++;
            pending_shapes.push_back(shape);
            shapes_sent++;
            clear_shape_state();
        end
    endtask

    task automatic flag_error(input string what, input longint want, input longint got);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
    endtask

    task automatic check_shape(input out_item_t got);
        out_item_t want;
        if (pending_shapes.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("result with nothing pending at %0t", $time);
        end
        else
        begin
            want = pending_shapes.pop_front();
            shapes_checked++;
            if (got.twice_area !== want.twice_area)
                flag_error("twice_area", want.twice_area, got.twice_area);
            if (got.min_x !== want.min_x)
                flag_error("min_x", want.min_x, got.min_x);
            if (got.min_y !== want.min_y)
                flag_error("min_y", want.min_y, got.min_y);
            if (got.max_x !== want.max_x)
                flag_error("max_x", want.max_x, got.max_x);
            if (got.max_y !== want.max_y)
                flag_error("max_y", want.max_y, got.max_y);
            if (got.vertex_count !== want.vertex_count)
                flag_error("vertex_count", want.vertex_count, got.vertex_count);
            if (got.area_overflow !== want.area_overflow)
                flag_error("area_overflow", want.area_overflow, got.area_overflow);
        end
    endtask

    // called at a clock edge; returns at the edge where the item is taken
    task automatic send_vertex(input logic signed [FIELD_W-1:0] vx, vy, input logic vlast);
        in_item_t v;
        int       gap;
        v.x  = vx;
        v.y  = vy;
        v.last = vlast;
        gap  = gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= v;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        track_vertex(v);
        vertices_sent++;
    endtask

    function automatic logic signed [FIELD_W-1:0] pick_coord(input coord_style_t style);
        int s;
        s = $urandom_range(0, 2000) - 1000;
        case (style)
            STYLE_FULL:  return FIELD_W'($urandom());
            STYLE_SMALL: return FIELD_W'(s);
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return FIELD_W'($urandom());
                    default: return FIELD_W'(s);
                endcase
            end
        endcase
    endfunction

    // single points and two-vertex polygons report zero area
    task automatic test_tiny_shapes();
        gaps_on = 1'b1;
        send_vertex(COORD_MIN, COORD_MAX, 1'b1);
        send_vertex(COORD_MAX, COORD_MIN, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b1);
    endtask

    task automatic test_extreme_shapes();
        gaps_on = 1'b1;
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b1);
        // same triangle, opposite winding
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MIN, COORD_MIN, 1'b1);
        send_vertex(24'sd0, 24'sd0, 1'b0);
        send_vertex(24'sd10, 24'sd0, 1'b0);
        send_vertex(24'sd10, 24'sd10, 1'b0);
        send_vertex(24'sd0, 24'sd10, 1'b1);
        // collinear points enclose nothing
        send_vertex(-24'sd5, -24'sd5, 1'b0);
        send_vertex(24'sd0, 24'sd0, 1'b0);
        send_vertex(24'sd5, 24'sd5, 1'b1);
    endtask

    task automatic test_random_shapes();
        int           stop_at;
        int           sides;
        int           k;
        coord_style_t style;
        stop_at = vertices_sent + RANDOM_VERTICES;
        while (vertices_sent < stop_at)
        begin
            gaps_on = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 9))
                0:       sides = 1;
                1:       sides = 2;
                2:       sides = $urandom_range(21, 60);
                default: sides = $urandom_range(3, 20);
            endcase
            style = coord_style_t'($urandom_range(0, 2));
            for (k = 0; k < sides; k++)
                send_vertex(pick_coord(style), pick_coord(style), k == sides - 1);
        end
    endtask

    initial
    begin : result_side
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        wait (rst_n === 1'b1);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            check_shape(out_data);
        end
    end

    initial
    begin : stimulus
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        gaps_on  = 1'b1;
        errors   = 0;
        clear_shape_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tiny_shapes();
        test_extreme_shapes();
        test_random_shapes();

        in_valid <= 1'b0;
        while (pending_shapes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d vertices in %0d polygons sent, %0d results checked",
                 vertices_sent, shapes_sent, shapes_checked);
        $display("%0d polygons saturated the area sum, %0d mismatches", sat_shapes, errors);
        if (errors == 0)
            $display("PASS polygon_bounds_and_area");
        else
            $display("FAIL polygon_bounds_and_area");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pba_pkg.sv
rtl/pba_queue.sv
rtl/pba_front.sv
rtl/pba_back.sv
rtl/polygon_bounds_and_area.sv
tb/tb.sv
